// ===== rtl/atlf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the prefix lookup for the AT line framer.
// Used by atlf_core and at_line_framer_with_length_payload; no dependencies.
package atlf_pkg;

  localparam int RX_BUF_SIZE = 256;
  localparam int LC_W        = $clog2(RX_BUF_SIZE);
  localparam int PREFIX_LEN  = 12;

  localparam logic [7:0]  CHAR_CR    = 8'h0D;
  localparam logic [7:0]  CHAR_LF    = 8'h0A;
  localparam logic [7:0]  CHAR_COMMA = 8'h2C;
  localparam logic [7:0]  CHAR_ZERO  = 8'h30;
  localparam logic [7:0]  CHAR_NINE  = 8'h39;
  localparam logic [15:0] NO_LENGTH  = 16'hFFFF;

  localparam logic [1:0] PH_PLAIN = 2'd0;
  localparam logic [1:0] PH_LEN   = 2'd1;
  localparam logic [1:0] PH_PAY   = 2'd2;

  typedef struct packed {
    logic [LC_W-1:0] line_count;
    logic [7:0]      previous_byte;
    logic            prefix_match;
    logic [1:0]      http_phase;
    logic [15:0]     length_value;
    logic            digits_ended;
    logic [15:0]     remaining_bytes;
    logic [7:0]      payload_index;
  } state_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [7:0]  position;
    logic        line_done;
    logic        dropped;
    logic        in_payload;
    logic [15:0] payload_length;
    logic [7:0]  payload_start;
  } result_t;

  localparam state_t STATE_RST = '{
    line_count:      '0,
    previous_byte:   8'h00,
    prefix_match:    1'b1,
    http_phase:      PH_PLAIN,
    length_value:    NO_LENGTH,
    digits_ended:    1'b0,
    remaining_bytes: 16'h0000,
    payload_index:   8'h00
  };

  // "+HTTPCLIENT:"
  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h2B;
      4'd1:    ch = 8'h48;
      4'd2:    ch = 8'h54;
      4'd3:    ch = 8'h54;
      4'd4:    ch = 8'h50;
      4'd5:    ch = 8'h43;
      4'd6:    ch = 8'h4C;
      4'd7:    ch = 8'h49;
      4'd8:    ch = 8'h45;
      4'd9:    ch = 8'h4E;
      4'd10:   ch = 8'h54;
      4'd11:   ch = 8'h3A;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/atlf_core.sv =====
`timescale 1ns / 1ps
// Single-pass update for one received byte: next framer state and the result.
// Depends on atlf_pkg.
module atlf_core (
  input  logic [7:0]       rx_byte,
  input  atlf_pkg::state_t cur,
  output atlf_pkg::state_t nxt,
  output atlf_pkg::result_t res
);

  logic [atlf_pkg::LC_W:0] n;
  logic                    crlf;
  logic                    done;
  logic                    drop;
  logic                    counted;
  logic                    is_digit;
  logic [15:0]             len_x10;
  atlf_pkg::state_t        s;

  assign n        = {1'b0, cur.line_count} + (atlf_pkg::LC_W+1)'(1);
  assign is_digit = (rx_byte >= atlf_pkg::CHAR_ZERO) && (rx_byte <= atlf_pkg::CHAR_NINE);

  always_comb begin
    s       = cur;
    done    = 1'b0;
    drop    = 1'b0;
    crlf    = 1'b0;
    counted = 1'b0;
    len_x10 = 16'h0000;
    if (n >= (atlf_pkg::LC_W+1)'(atlf_pkg::RX_BUF_SIZE)) begin
      s.line_count    = '0;
      s.previous_byte = 8'h00;
      s.prefix_match  = 1'b1;
      drop            = 1'b1;
    end else begin
      if (cur.http_phase == atlf_pkg::PH_PAY && cur.remaining_bytes != 16'h0000) begin
        s.remaining_bytes = cur.remaining_bytes - 16'd1;
      end
      crlf = (cur.previous_byte == atlf_pkg::CHAR_CR) && (rx_byte == atlf_pkg::CHAR_LF);
      if (crlf && n == (atlf_pkg::LC_W+1)'(2)) begin
        s.line_count    = '0;
        s.previous_byte = 8'h00;
        s.prefix_match  = 1'b1;
        drop            = 1'b1;
      end else if (crlf && (s.http_phase != atlf_pkg::PH_PAY ||
                            s.remaining_bytes == 16'h0000)) begin
        done = 1'b1;
      end else begin
        s.line_count    = n[atlf_pkg::LC_W-1:0];
        s.previous_byte = rx_byte;
        if (32'(cur.line_count) < 32'(atlf_pkg::PREFIX_LEN) &&
            rx_byte != atlf_pkg::prefix_char(cur.line_count[3:0])) begin
          s.prefix_match = 1'b0;
        end
        if (32'(n) == 32'(atlf_pkg::PREFIX_LEN)) begin
          if (s.prefix_match) begin
            s.http_phase    = atlf_pkg::PH_LEN;
            s.length_value  = 16'h0000;
            s.digits_ended  = 1'b0;
            s.payload_index = 8'(atlf_pkg::PREFIX_LEN);
          end else begin
            s.http_phase = atlf_pkg::PH_PLAIN;
          end
        end
        if (s.http_phase == atlf_pkg::PH_LEN) begin
          counted = 32'(cur.line_count) >= 32'(s.payload_index);
          if (rx_byte == atlf_pkg::CHAR_COMMA) begin
            if (!counted) begin
              s.length_value = 16'h0000;
            end
            s.remaining_bytes = s.length_value;
            s.payload_index   = 8'(n);
            s.http_phase      = atlf_pkg::PH_PAY;
          end else if (counted && !s.digits_ended) begin
            if (is_digit) begin
              len_x10        = {s.length_value[12:0], 3'b000} + {s.length_value[14:0], 1'b0};
              s.length_value = len_x10 + {12'h000, rx_byte[3:0] - 4'd0};
            end else begin
              s.digits_ended = 1'b1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    nxt                = done ? atlf_pkg::STATE_RST : s;
    res.data_byte      = rx_byte;
    res.position       = 8'(cur.line_count);
    res.line_done      = done;
    res.dropped        = drop;
    res.in_payload     = (s.http_phase == atlf_pkg::PH_PAY);
    res.payload_length = res.in_payload ? s.length_value : atlf_pkg::NO_LENGTH;
    res.payload_start  = res.in_payload ? s.payload_index : 8'h00;
  end

endmodule

// ===== rtl/at_line_framer_with_length_payload.sv =====
`timescale 1ns / 1ps
// Top level of the AT line framer: input register, state, core and result register.
// Depends on atlf_pkg and atlf_core.
//
// One result per received byte, one byte per cycle sustained while out_tready is high:
// a byte is held in the input register, the state update and result are computed in a
// single pass by atlf_core, and the result register delivers it. The input side keeps
// accepting while a result waits, and stalls only when both the input and result
// registers are full. Lines end at CR LF (tlast set); overflow at RX_BUF_SIZE bytes and
// bare CR LF are flagged as dropped. Lines starting with "+HTTPCLIENT:" parse a decimal
// length up to the first comma and then hold the line open until that many payload
// bytes have passed.
module at_line_framer_with_length_payload (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] data_byte, [15:8] position,
                                  // [31:16] payload_length, [39:32] payload_start
  output logic        out_tlast,  // line_done
  output logic [1:0]  out_tuser   // [0] dropped, [1] in_payload
);

  logic              in_valid_r;
  logic [7:0]        in_byte_r;
  logic              out_valid_r;
  logic              advance;
  atlf_pkg::state_t  state_r;
  atlf_pkg::state_t  state_nxt;
  atlf_pkg::result_t res_nxt;
  atlf_pkg::result_t res_r;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  atlf_core u_core (
    .rx_byte (in_byte_r),
    .cur     (state_r),
    .nxt     (state_nxt),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= atlf_pkg::STATE_RST;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.payload_start, res_r.payload_length, res_r.position,
                       res_r.data_byte};
  assign out_tlast  = res_r.line_done;
  assign out_tuser  = {res_r.in_payload, res_r.dropped};

  a_done_xor_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.line_done && res_r.dropped))
    else $error("line_done and dropped set together");

  a_idle_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.in_payload) |->
      (res_r.payload_length == atlf_pkg::NO_LENGTH && res_r.payload_start == 8'h00))
    else $error("payload fields set outside payload");

  a_clear_after_line: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_nxt.line_done) |=>
      (state_r.line_count == '0 && state_r.http_phase == atlf_pkg::PH_PLAIN))
    else $error("state not cleared after completed line");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(state_r.line_count) < 32'(atlf_pkg::RX_BUF_SIZE))
    else $error("line count reached buffer size");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(res_r)))
    else $error("result changed while stalled");

endmodule
